// ===== rtl/ddwo_pkg.sv =====
package ddwo_pkg;

   localparam int FRAC_BITS  = 23;
   localparam int ENTRY_W    = 16;
   localparam int INC_W      = 31;
   localparam int GAIN_W     = 16;
   localparam int SAMPLE_W   = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int MUL_W      = 25;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 40;
   localparam int SCL_W      = 57;
   localparam int OUT_SHIFT  = 38;
   localparam int LO_W       = 24;
   localparam int HI_W       = ACC_W - LO_W;
   localparam int HIP_W      = HI_W + GAIN_W + 1;
   localparam int LOP_W      = LO_W + GAIN_W;
   localparam int RAMP_W     = 17;
   localparam int RAMP_SPAN  = 65536;

   localparam logic [INC_W-1:0]  INC_RESET  = 31'd21399;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd3277;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ENTRY_W-1:0]  entry_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_INC_ONE = 2'd0,
      CSR_PHASE_INC_TWO = 2'd1,
      CSR_OUTPUT_GAIN   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_VONE,
      ST_VTWO,
      ST_SUM,
      ST_GLO,
      ST_GHI,
      ST_RND
   } osc_state_type;

endpackage

// ===== rtl/ddwo_if.sv =====
interface ddwo_req_if;
   logic valid;
   logic ready;
   logic sample_request;

   modport source (output valid, output sample_request, input ready);
   modport sink   (input valid, input sample_request, output ready);
endinterface

interface ddwo_rsp_if;
   logic                 valid;
   logic                 ready;
   ddwo_pkg::sample_type audio_sample;

   modport source (output valid, output audio_sample, input ready);
   modport sink   (input valid, input audio_sample, output ready);
endinterface

interface ddwo_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ddwo_pkg::CSR_IDX_W-1:0]       index;
   logic [ddwo_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/detuned_dual_wavetable_oscillator_top.sv =====
// Two-voice detuned sawtooth oscillator. After reset the sawtooth table is written into an
// internal TABLE_DEPTH x 16 memory, one entry per cycle, so req_bus.ready stays low until
// the whole table is written (configuration writes are taken throughout). A transfer with
// sample_request set produces one Q3.15 sample on rsp_bus; a transfer with it clear is taken
// and produces nothing. Each sample runs through the states VONE, VTWO, SUM, GLO, GHI and
// RND before its result is loaded: the two-port table memory serves one voice per cycle
// (entry below and above the phase) and a single 25x25 multiplier is used four times (two
// interpolations, then the gain in two halves). The next request is taken once the state
// machine is back in IDLE and the phase wrap, a restoring subtraction of shifted limits,
// has finished. A finished sample waits in the output register without blocking the next
// request; the next result waits in RND until that register is free. Increment and gain
// registers are written through csr_bus, which is always ready.
module detuned_dual_wavetable_oscillator_top #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   ddwo_req_if.sink   req_bus,
   ddwo_rsp_if.source rsp_bus,
   ddwo_csr_if.sink   csr_bus
);

   localparam int FB    = ddwo_pkg::FRAC_BITS;
   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int PH_W  = AW + FB;
   localparam int X_W   = ((PH_W > ddwo_pkg::INC_W) ? PH_W : ddwo_pkg::INC_W) + 1;
   localparam int CW    = X_W + 1;
   localparam longint unsigned PH_LIMIT = 64'(TABLE_DEPTH) << FB;
   localparam int RED_STEPS = $clog2(((64'd1 << ddwo_pkg::INC_W) / PH_LIMIT) + 64'd2);
   localparam int RCW   = $clog2(RED_STEPS + 1);
   localparam logic [CW-1:0] LIM_C = CW'(PH_LIMIT);
   localparam int DM1    = TABLE_DEPTH - 1;
   localparam int Q_STEP = ddwo_pkg::RAMP_SPAN / DM1;
   localparam int R_STEP = ddwo_pkg::RAMP_SPAN % DM1;
   localparam int R_INIT = DM1 / 2;
   localparam logic [AW-1:0] LAST_IDX = AW'(DM1);

   ddwo_pkg::osc_state_type state_ff, state_in;

   logic [ddwo_pkg::INC_W-1:0]  inc_one_ff, inc_two_ff;
   logic [ddwo_pkg::GAIN_W-1:0] gain_ff;

   logic [PH_W-1:0] phase_one_ff, phase_two_ff;
   logic [X_W-1:0]  nxt_one_ff, nxt_two_ff;
   logic [RCW-1:0]  red_cnt_ff;

   logic [AW-1:0]                fill_idx_ff;
   logic [ddwo_pkg::RAMP_W-1:0]  fill_q_ff;
   logic [AW-1:0]                fill_r_ff;
   logic [AW:0]                  fill_rsum;
   ddwo_pkg::entry_type          fill_value;
   logic                         fill_we;

   ddwo_pkg::entry_type wave_mem [TABLE_DEPTH];
   ddwo_pkg::entry_type rd_lo_ff, rd_hi_ff;
   logic [AW-1:0]       rd_addr_lo, rd_addr_hi;
   logic [AW-1:0]       lo_one, hi_one, lo_two, hi_two;

   logic signed [ddwo_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [ddwo_pkg::PROD_W-1:0] prod_ff;
   logic signed [ddwo_pkg::ENTRY_W:0]  diff;
   ddwo_pkg::entry_type                base_ff;
   logic signed [ddwo_pkg::ACC_W-1:0]  acc_ff, base_ext;
   logic [ddwo_pkg::LOP_W-1:0]         lowp_ff;
   logic signed [ddwo_pkg::SCL_W-1:0]  scaled;

   logic                 rsp_valid_ff;
   ddwo_pkg::sample_type rsp_sample_ff;
   logic                 req_ready;
   logic                 out_load;

   logic [RCW-1:0] red_k;
   logic [CW-1:0]  red_lim;
   logic [X_W-1:0] red_one, red_two;

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.audio_sample = rsp_sample_ff;
   assign csr_bus.ready        = 1'b1;

   assign lo_one = phase_one_ff[PH_W-1:FB];
   assign lo_two = phase_two_ff[PH_W-1:FB];
   assign hi_one = (lo_one == LAST_IDX) ? '0 : lo_one + AW'(1);
   assign hi_two = (lo_two == LAST_IDX) ? '0 : lo_two + AW'(1);

   assign fill_rsum  = {1'b0, fill_r_ff} + (AW + 1)'(R_STEP);
   assign fill_value = fill_q_ff[ddwo_pkg::RAMP_W-1] ? ddwo_pkg::entry_type'(16'sh7FFF)
                                                     : {~fill_q_ff[15], fill_q_ff[14:0]};

   assign diff     = {rd_hi_ff[15], rd_hi_ff} - {rd_lo_ff[15], rd_lo_ff};
   assign base_ext = {base_ff[15], base_ff, {FB{1'b0}}};

   assign red_k   = red_cnt_ff - RCW'(1);
   assign red_lim = LIM_C << red_k;
   assign red_one = ({1'b0, nxt_one_ff} >= red_lim) ? nxt_one_ff - red_lim[X_W-1:0] : nxt_one_ff;
   assign red_two = ({1'b0, nxt_two_ff} >= red_lim) ? nxt_two_ff - red_lim[X_W-1:0] : nxt_two_ff;

   assign scaled = {prod_ff[ddwo_pkg::HIP_W-1:0], {ddwo_pkg::LO_W{1'b0}}}
                 + {{(ddwo_pkg::SCL_W - ddwo_pkg::LOP_W){1'b0}}, lowp_ff}
                 + (ddwo_pkg::SCL_W'(1) << (ddwo_pkg::OUT_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddwo_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mul_a      = '0;
      mul_b      = '0;
      rd_addr_lo = lo_one;
      rd_addr_hi = hi_one;
      req_ready  = 1'b0;
      fill_we    = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ddwo_pkg::ST_FILL: begin
            fill_we = 1'b1;
            if (fill_idx_ff == LAST_IDX) begin
               state_in = ddwo_pkg::ST_IDLE;
            end
         end
         ddwo_pkg::ST_IDLE: begin
            req_ready = (red_cnt_ff == '0);
            if (req_ready && req_bus.valid && req_bus.sample_request) begin
               state_in = ddwo_pkg::ST_VONE;
            end
         end
         ddwo_pkg::ST_VONE: begin
            mul_a      = {{(ddwo_pkg::MUL_W - ddwo_pkg::ENTRY_W - 1){diff[16]}}, diff};
            mul_b      = {{(ddwo_pkg::MUL_W - FB){1'b0}}, phase_one_ff[FB-1:0]};
            rd_addr_lo = lo_two;
            rd_addr_hi = hi_two;
            state_in   = ddwo_pkg::ST_VTWO;
         end
         ddwo_pkg::ST_VTWO: begin
            mul_a    = {{(ddwo_pkg::MUL_W - ddwo_pkg::ENTRY_W - 1){diff[16]}}, diff};
            mul_b    = {{(ddwo_pkg::MUL_W - FB){1'b0}}, phase_two_ff[FB-1:0]};
            state_in = ddwo_pkg::ST_SUM;
         end
         ddwo_pkg::ST_SUM: begin
            state_in = ddwo_pkg::ST_GLO;
         end
         ddwo_pkg::ST_GLO: begin
            mul_a    = {1'b0, acc_ff[ddwo_pkg::LO_W-1:0]};
            mul_b    = {{(ddwo_pkg::MUL_W - ddwo_pkg::GAIN_W){1'b0}}, gain_ff};
            state_in = ddwo_pkg::ST_GHI;
         end
         ddwo_pkg::ST_GHI: begin
            mul_a    = {{(ddwo_pkg::MUL_W - ddwo_pkg::HI_W){acc_ff[ddwo_pkg::ACC_W-1]}},
                        acc_ff[ddwo_pkg::ACC_W-1:ddwo_pkg::LO_W]};
            mul_b    = {{(ddwo_pkg::MUL_W - ddwo_pkg::GAIN_W){1'b0}}, gain_ff};
            state_in = ddwo_pkg::ST_RND;
         end
         ddwo_pkg::ST_RND: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ddwo_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // table memory: ramp written once after reset, two read ports
   always_ff @(posedge clock) begin
      if (fill_we) begin
         wave_mem[fill_idx_ff] <= fill_value;
      end
      rd_lo_ff <= wave_mem[rd_addr_lo];
      rd_hi_ff <= wave_mem[rd_addr_hi];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_idx_ff <= '0;
         fill_q_ff   <= '0;
         fill_r_ff   <= AW'(R_INIT);
      end else if (fill_we) begin
         fill_idx_ff <= fill_idx_ff + AW'(1);
         if (fill_rsum >= (AW + 1)'(DM1)) begin
            fill_r_ff <= AW'(fill_rsum - (AW + 1)'(DM1));
            fill_q_ff <= fill_q_ff + ddwo_pkg::RAMP_W'(Q_STEP + 1);
         end else begin
            fill_r_ff <= fill_rsum[AW-1:0];
            fill_q_ff <= fill_q_ff + ddwo_pkg::RAMP_W'(Q_STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_one_ff <= ddwo_pkg::INC_RESET;
         inc_two_ff <= ddwo_pkg::INC_RESET;
         gain_ff    <= ddwo_pkg::GAIN_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ddwo_pkg::CSR_PHASE_INC_ONE: inc_one_ff <= csr_bus.data[ddwo_pkg::INC_W-1:0];
            ddwo_pkg::CSR_PHASE_INC_TWO: inc_two_ff <= csr_bus.data[ddwo_pkg::INC_W-1:0];
            ddwo_pkg::CSR_OUTPUT_GAIN:   gain_ff    <= csr_bus.data[ddwo_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // phase advance: add in VTWO, then wrap by restoring subtraction of shifted limits
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_one_ff <= '0;
         phase_two_ff <= '0;
         red_cnt_ff   <= '0;
      end else if (state_ff == ddwo_pkg::ST_VTWO) begin
         red_cnt_ff <= RCW'(RED_STEPS);
      end else if (red_cnt_ff != '0) begin
         red_cnt_ff <= red_cnt_ff - RCW'(1);
         if (red_cnt_ff == RCW'(1)) begin
            phase_one_ff <= red_one[PH_W-1:0];
            phase_two_ff <= red_two[PH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ddwo_pkg::ST_VTWO) begin
         nxt_one_ff <= X_W'(phase_one_ff) + X_W'(inc_one_ff);
         nxt_two_ff <= X_W'(phase_two_ff) + X_W'(inc_two_ff);
      end else begin
         nxt_one_ff <= red_one;
         nxt_two_ff <= red_two;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ddwo_pkg::ST_VONE: begin
            prod_ff <= mul_a * mul_b;
            base_ff <= rd_lo_ff;
         end
         ddwo_pkg::ST_VTWO: begin
            acc_ff  <= base_ext + prod_ff[ddwo_pkg::ACC_W-1:0];
            prod_ff <= mul_a * mul_b;
            base_ff <= rd_lo_ff;
         end
         ddwo_pkg::ST_SUM: begin
            acc_ff <= acc_ff + base_ext + prod_ff[ddwo_pkg::ACC_W-1:0];
         end
         ddwo_pkg::ST_GLO: begin
            prod_ff <= mul_a * mul_b;
         end
         ddwo_pkg::ST_GHI: begin
            lowp_ff <= prod_ff[ddwo_pkg::LOP_W-1:0];
            prod_ff <= mul_a * mul_b;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= scaled[ddwo_pkg::SCL_W-1:ddwo_pkg::OUT_SHIFT];
      end
   end

   a_result_from_round : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ddwo_pkg::ST_RND))
      else $error("result raised outside the rounding step");

   a_no_result_in_fill : assert property (@(posedge clock) disable iff (reset)
      state_ff == ddwo_pkg::ST_FILL |-> !rsp_valid_ff)
      else $error("result present while the table is being loaded");

   a_phase_in_range : assert property (@(posedge clock) disable iff (reset)
      (CW'(phase_one_ff) < LIM_C) && (CW'(phase_two_ff) < LIM_C))
      else $error("phase beyond table length");

   a_request_starts : assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_ready && req_bus.sample_request |=> state_ff == ddwo_pkg::ST_VONE)
      else $error("accepted request did not start a sample");

endmodule

// ===== dv/ddwo_sample_checker.sv =====
`timescale 1ns / 100ps

module ddwo_sample_checker (
   input  logic clock,
   input  logic reset,
   ddwo_req_if  req_mon,
   ddwo_rsp_if  rsp_mon,
   ddwo_csr_if  csr_mon,
   output int   fail_count,
   output int   samples_owed
);

   localparam int     DEPTH        = 512;
   localparam int     IDX_W        = 9;
   localparam int     PHASE_W      = IDX_W + ddwo_pkg::FRAC_BITS;
   localparam longint RAMP_DEN     = DEPTH - 1;
   localparam longint ENTRY_TOP    = 32767;
   localparam longint SAMPLE_MAX   = (longint'(1) <<< (ddwo_pkg::SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN   = -(longint'(1) <<< (ddwo_pkg::SAMPLE_W - 1));

   ddwo_pkg::entry_type           saw_table [DEPTH];
   logic [PHASE_W-1:0]            phase_a;
   logic [PHASE_W-1:0]            phase_b;
   logic [ddwo_pkg::INC_W-1:0]    step_a;
   logic [ddwo_pkg::INC_W-1:0]    step_b;
   logic [ddwo_pkg::GAIN_W-1:0]   gain;
   ddwo_pkg::sample_type          expected_samples [$];
   ddwo_pkg::sample_type          want;
   longint                        ramp;
   int                            faults = 0;

   function automatic longint voice_level(input logic [PHASE_W-1:0] ph);
      logic [IDX_W-1:0] lo_idx;
      logic [IDX_W-1:0] hi_idx;
      longint           frac;
      lo_idx = ph[PHASE_W-1:ddwo_pkg::FRAC_BITS];
      hi_idx = lo_idx + 1'b1;
      frac   = longint'(ph[ddwo_pkg::FRAC_BITS-1:0]);
      return longint'(saw_table[lo_idx]) * ((longint'(1) <<< ddwo_pkg::FRAC_BITS) - frac)
           + longint'(saw_table[hi_idx]) * frac;
   endfunction

   function automatic ddwo_pkg::sample_type predict_sample();
      longint mix;
      mix = (voice_level(phase_a) + voice_level(phase_b)) * longint'(gain);
      // round half up, drop the fraction
      mix = (mix + (longint'(1) <<< (ddwo_pkg::OUT_SHIFT - 1))) >>> ddwo_pkg::OUT_SHIFT;
      if (mix > SAMPLE_MAX) mix = SAMPLE_MAX;
      if (mix < SAMPLE_MIN) mix = SAMPLE_MIN;
      return ddwo_pkg::sample_type'(mix);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < DEPTH; n++) begin
            ramp = (longint'(ddwo_pkg::RAMP_SPAN) * n + RAMP_DEN / 2) / RAMP_DEN - 32768;
            saw_table[n] = ddwo_pkg::entry_type'((ramp > ENTRY_TOP) ? ENTRY_TOP : ramp);
         end
         phase_a = '0;
         phase_b = '0;
         step_a  = ddwo_pkg::INC_RESET;
         step_b  = ddwo_pkg::INC_RESET;
         gain    = ddwo_pkg::GAIN_RESET;
         expected_samples.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               ddwo_pkg::CSR_PHASE_INC_ONE: step_a = csr_mon.data[ddwo_pkg::INC_W-1:0];
               ddwo_pkg::CSR_PHASE_INC_TWO: step_b = csr_mon.data[ddwo_pkg::INC_W-1:0];
               ddwo_pkg::CSR_OUTPUT_GAIN:   gain   = csr_mon.data[ddwo_pkg::GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               faults++;
               $display("%0t: audio_sample expected none actual %0d",
                        $time, rsp_mon.audio_sample);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_mon.audio_sample !== want) begin
                  faults++;
                  $display("%0t: audio_sample expected %0d actual %0d",
                           $time, want, rsp_mon.audio_sample);
               end
            end
         end
         if (req_mon.valid && req_mon.ready && req_mon.sample_request) begin
            expected_samples.push_back(predict_sample());
            // advance both voices, wrapping at the table length
            phase_a = phase_a + step_a;
            phase_b = phase_b + step_b;
         end
      end
      fail_count   <= faults;
      samples_owed <= expected_samples.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int STALL_PERCENT = 21;
   localparam int HOLD_CYCLES   = 90;
   localparam int ITEM_TARGET   = 750;
   localparam int GAIN_PAD      = ddwo_pkg::CSR_DATA_W - ddwo_pkg::GAIN_W;

   localparam logic [ddwo_pkg::INC_W-1:0]     INC_MAX   = '1;
   localparam logic [ddwo_pkg::INC_W-1:0]     ONE_ENTRY = 31'd1 << ddwo_pkg::FRAC_BITS;
   localparam logic [ddwo_pkg::GAIN_W-1:0]    GAIN_MAX  = '1;
   localparam logic [ddwo_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock;
   logic reset;
   int   cycles = 0;
   int   fail_count;
   int   samples_owed;
   int   requests_sent = 0;
   bit   steady = 1'b0;
   int   hold_asked = 0;
   int   hold_done = 0;

   ddwo_req_if req_bus ();
   ddwo_rsp_if rsp_bus ();
   ddwo_csr_if csr_bus ();

   detuned_dual_wavetable_oscillator_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ddwo_sample_checker sample_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (fail_count),
      .samples_owed (samples_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_done != hold_asked) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
         end
      end
   end

   task automatic send_request(input logic wanted);
      while (!steady && $urandom_range(99) < STALL_PERCENT) begin
         req_bus.valid          <= 1'b0;
         req_bus.sample_request <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.sample_request <= wanted;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   task automatic pause_requests();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (samples_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ddwo_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ddwo_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_settings(input logic [ddwo_pkg::INC_W-1:0]  inc_one,
                                input logic [ddwo_pkg::INC_W-1:0]  inc_two,
                                input logic [ddwo_pkg::GAIN_W-1:0] level);
      write_reg(ddwo_pkg::CSR_PHASE_INC_ONE, inc_one);
      write_reg(ddwo_pkg::CSR_PHASE_INC_TWO, inc_two);
      // upper data bits must be ignored by the gain register
      write_reg(ddwo_pkg::CSR_OUTPUT_GAIN, {GAIN_PAD'($urandom), level});
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [ddwo_pkg::INC_W-1:0] pick_increment();
      case ($urandom_range(5))
         0:       return '0;
         1:       return INC_MAX;
         2:       return ddwo_pkg::INC_W'($urandom_range(1 << 18));
         default: return ddwo_pkg::INC_W'($urandom);
      endcase
   endfunction

   function automatic logic [ddwo_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(4))
         0:       return '0;
         1:       return GAIN_MAX;
         default: return ddwo_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   initial begin
      int phase_no;
      int burst;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.sample_request <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= '0;
      csr_bus.data           <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      repeat (4) send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      pause_requests();

      load_settings(INC_MAX, '0, GAIN_MAX);
      repeat (6) send_request(1'b1);
      send_request(1'b0);
      pause_requests();

      write_reg(CSR_SPARE, INC_MAX);
      load_settings(ONE_ENTRY, INC_MAX, '0);
      repeat (4) send_request(1'b1);
      pause_requests();

      load_settings('0, ONE_ENTRY - 1'b1, GAIN_MAX);
      repeat (5) send_request(1'b1);
      pause_requests();

      phase_no = 0;
      while (requests_sent < ITEM_TARGET) begin
         if ($urandom_range(3) == 0) write_reg(CSR_SPARE, ddwo_pkg::CSR_DATA_W'($urandom));
         load_settings(pick_increment(), pick_increment(), pick_gain());
         steady <= (phase_no == 2);
         if (phase_no == 4) hold_asked <= hold_asked + 1;
         burst = $urandom_range(40, 110);
         if (burst > ITEM_TARGET - requests_sent) burst = ITEM_TARGET - requests_sent;
         repeat (burst) send_request($urandom_range(99) >= 10);
         pause_requests();
         phase_no++;
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
